>>> rtl/kpvf_pkg.sv
// Shared types, codes and the update sequence for the position/velocity Kalman filter.
package kpvf_pkg;

   // Configuration register indexes
   localparam logic [1:0] CSR_TIME_STEP  = 2'd0;
   localparam logic [1:0] CSR_Q_POSITION = 2'd1;
   localparam logic [1:0] CSR_Q_VELOCITY = 2'd2;
   localparam logic [1:0] CSR_R_NOISE    = 2'd3;

   // Configuration reset values
   localparam logic [16:0] TIME_STEP_RST  = 17'd655;
   localparam logic [30:0] Q_POSITION_RST = 31'd655;
   localparam logic [30:0] Q_VELOCITY_RST = 31'd655;
   localparam logic [30:0] R_NOISE_RST    = 31'd6554;

   // Operand sources
   typedef enum logic [4:0] {
      SRC_POS, SRC_VEL, SRC_CPP, SRC_CPV, SRC_CVV, SRC_X0P, SRC_P00, SRC_P01,
      SRC_P11, SRC_S, SRC_K0, SRC_K1, SRC_Y, SRC_OM, SRC_T, SRC_DT, SRC_QP,
      SRC_QV, SRC_RN, SRC_ONE, SRC_MEAS
   } src_type;

   localparam int NUM_SRC = 21;

   // Result destinations (the gains are written by the divider only)
   typedef enum logic [3:0] {
      DST_POS, DST_VEL, DST_CPP, DST_CPV, DST_CVV, DST_X0P, DST_P00, DST_P01,
      DST_P11, DST_S, DST_Y, DST_OM, DST_T
   } dst_type;

   typedef enum logic [2:0] {
      OP_NOP, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_CLAMP, OP_RESTART
   } op_type;

   typedef struct packed {
      op_type  op;
      src_type a;
      src_type b;
      dst_type dst;
   } uop_type;

   // Controller to datapath
   typedef struct packed {
      logic    start;
      uop_type uop;
      logic    accept;
      logic    load_out;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic done;
   } status_type;

   localparam int STEP_W = 5;
   localparam logic [STEP_W-1:0] LAST_STEP = 5'd24;

   function automatic uop_type mk(input op_type op, input src_type a, input src_type b,
                                  input dst_type dst);
      uop_type u;
      u.op  = op;
      u.a   = a;
      u.b   = b;
      u.dst = dst;
      return u;
   endfunction

   // Measurement update, one operation per step
   function automatic uop_type uop_at(input logic [STEP_W-1:0] step);
      uop_type u;
      unique case (step)
         5'd0:    u = mk(OP_ADD,   SRC_CPV,  SRC_CPV, DST_T);
         5'd1:    u = mk(OP_MUL,   SRC_DT,   SRC_T,   DST_T);
         5'd2:    u = mk(OP_ADD,   SRC_CPP,  SRC_T,   DST_P00);
         5'd3:    u = mk(OP_MUL,   SRC_DT,   SRC_DT,  DST_T);
         5'd4:    u = mk(OP_MUL,   SRC_T,    SRC_CVV, DST_T);
         5'd5:    u = mk(OP_ADD,   SRC_P00,  SRC_T,   DST_P00);
         5'd6:    u = mk(OP_ADD,   SRC_P00,  SRC_QP,  DST_P00);
         5'd7:    u = mk(OP_MUL,   SRC_DT,   SRC_CVV, DST_T);
         5'd8:    u = mk(OP_ADD,   SRC_CPV,  SRC_T,   DST_P01);
         5'd9:    u = mk(OP_ADD,   SRC_CVV,  SRC_QV,  DST_P11);
         5'd10:   u = mk(OP_ADD,   SRC_P00,  SRC_RN,  DST_S);
         5'd11:   u = mk(OP_MUL,   SRC_DT,   SRC_VEL, DST_T);
         5'd12:   u = mk(OP_ADD,   SRC_POS,  SRC_T,   DST_X0P);
         5'd13:   u = mk(OP_DIV,   SRC_P00,  SRC_P01, DST_T);
         5'd14:   u = mk(OP_SUB,   SRC_MEAS, SRC_X0P, DST_Y);
         5'd15:   u = mk(OP_MUL,   SRC_K0,   SRC_Y,   DST_T);
         5'd16:   u = mk(OP_ADD,   SRC_X0P,  SRC_T,   DST_POS);
         5'd17:   u = mk(OP_MUL,   SRC_K1,   SRC_Y,   DST_T);
         5'd18:   u = mk(OP_ADD,   SRC_VEL,  SRC_T,   DST_VEL);
         5'd19:   u = mk(OP_SUB,   SRC_ONE,  SRC_K0,  DST_OM);
         5'd20:   u = mk(OP_MUL,   SRC_OM,   SRC_P00, DST_CPP);
         5'd21:   u = mk(OP_MUL,   SRC_OM,   SRC_P01, DST_CPV);
         5'd22:   u = mk(OP_MUL,   SRC_K1,   SRC_P01, DST_T);
         5'd23:   u = mk(OP_SUB,   SRC_P11,  SRC_T,   DST_CVV);
         5'd24:   u = mk(OP_CLAMP, SRC_CPP,  SRC_CVV, DST_CPP);
         default: u = mk(OP_NOP,   SRC_POS,  SRC_POS, DST_T);
      endcase
      return u;
   endfunction

endpackage

>>> rtl/kpvf_datapath.sv
// Datapath: filter state, configuration, saturating adder, multiplier and divider.
module kpvf_datapath #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [1:0]            csr_index,
   input  logic [31:0]           csr_data,
   input  logic [31:0]           meas_in,
   input  kpvf_pkg::cmd_type     cmd,
   output kpvf_pkg::status_type  status,
   output logic [31:0]           position,
   output logic [31:0]           velocity
);

   localparam int DW = DATA_WIDTH;
   localparam int FB = FRAC_BITS;
   localparam int AW = (DW > 32) ? DW : 32;   // operand width
   localparam int HW = (AW + 1) / 2;          // multiplier half width
   localparam int PW = 4 * HW;                // product accumulator width
   localparam int DN = DW + FB;               // divider iterations
   localparam int CW = $clog2(DN + 1);
   localparam logic [2:0] MUL_LAST_PHASE = 3'd4;

   localparam logic signed [AW:0] VMAX_W = {{(AW-DW+2){1'b0}}, {(DW-1){1'b1}}};
   localparam logic signed [AW:0] VMIN_W = ~VMAX_W;
   localparam logic signed [DW-1:0] ONE_V =
      (FB <= DW - 2) ? (DW'(1) << FB) : {1'b0, {(DW-1){1'b1}}};
   localparam logic signed [AW-1:0] O_MAX = AW'(32'sh7fffffff);
   localparam logic signed [AW-1:0] O_MIN = AW'($signed(32'h80000000));

   function automatic logic signed [DW-1:0] sat_dw(input logic signed [AW:0] v);
      if (v > VMAX_W) return VMAX_W[DW-1:0];
      else if (v < VMIN_W) return VMIN_W[DW-1:0];
      else return v[DW-1:0];
   endfunction

   function automatic logic [AW-1:0] mag_aw(input logic signed [AW-1:0] v);
      logic [AW-1:0] u;
      u = v;
      return u[AW-1] ? (~u + 1'b1) : u;
   endfunction

   function automatic logic [31:0] out32(input logic signed [DW-1:0] v);
      logic signed [AW-1:0] x;
      x = AW'(v);
      if (x > O_MAX) x = O_MAX;
      else if (x < O_MIN) x = O_MIN;
      return x[31:0];
   endfunction

   // Configuration
   logic [16:0] dt_ff;
   logic [30:0] qp_ff, qv_ff, rn_ff;

   // Filter state and scratch values
   logic signed [DW-1:0] pos_ff, vel_ff, cpp_ff, cpv_ff, cvv_ff;
   logic signed [DW-1:0] x0p_ff, p00_ff, p01_ff, p11_ff, s_ff, k0_ff, k1_ff;
   logic signed [DW-1:0] y_ff, om_ff, t_ff;
   logic signed [31:0]   meas_ff;
   logic [31:0]          pos_out_ff, vel_out_ff;
   logic                 done_ff;

   // Operand selection
   localparam int NUM_SRC_L = kpvf_pkg::NUM_SRC;
   logic signed [AW-1:0] src_val [NUM_SRC_L];
   logic signed [AW-1:0] op_a, op_b;

   always_comb begin
      src_val[kpvf_pkg::SRC_POS]  = AW'(pos_ff);
      src_val[kpvf_pkg::SRC_VEL]  = AW'(vel_ff);
      src_val[kpvf_pkg::SRC_CPP]  = AW'(cpp_ff);
      src_val[kpvf_pkg::SRC_CPV]  = AW'(cpv_ff);
      src_val[kpvf_pkg::SRC_CVV]  = AW'(cvv_ff);
      src_val[kpvf_pkg::SRC_X0P]  = AW'(x0p_ff);
      src_val[kpvf_pkg::SRC_P00]  = AW'(p00_ff);
      src_val[kpvf_pkg::SRC_P01]  = AW'(p01_ff);
      src_val[kpvf_pkg::SRC_P11]  = AW'(p11_ff);
      src_val[kpvf_pkg::SRC_S]    = AW'(s_ff);
      src_val[kpvf_pkg::SRC_K0]   = AW'(k0_ff);
      src_val[kpvf_pkg::SRC_K1]   = AW'(k1_ff);
      src_val[kpvf_pkg::SRC_Y]    = AW'(y_ff);
      src_val[kpvf_pkg::SRC_OM]   = AW'(om_ff);
      src_val[kpvf_pkg::SRC_T]    = AW'(t_ff);
      src_val[kpvf_pkg::SRC_DT]   = $signed(AW'(dt_ff));
      src_val[kpvf_pkg::SRC_QP]   = $signed(AW'(qp_ff));
      src_val[kpvf_pkg::SRC_QV]   = $signed(AW'(qv_ff));
      src_val[kpvf_pkg::SRC_RN]   = $signed(AW'(rn_ff));
      src_val[kpvf_pkg::SRC_ONE]  = AW'(ONE_V);
      src_val[kpvf_pkg::SRC_MEAS] = AW'(sat_dw((AW+1)'(meas_ff)));
      op_a = src_val[cmd.uop.a];
      op_b = src_val[cmd.uop.b];
   end

   // Saturating add / subtract
   logic signed [AW:0]   alu_sum;
   logic signed [DW-1:0] alu_res;
   logic                 alu_wr;

   assign alu_sum = (cmd.uop.op == kpvf_pkg::OP_SUB) ? ((AW+1)'(op_a) - (AW+1)'(op_b))
                                                     : ((AW+1)'(op_a) + (AW+1)'(op_b));
   assign alu_res = sat_dw(alu_sum);
   assign alu_wr  = cmd.start && (cmd.uop.op == kpvf_pkg::OP_ADD ||
                                  cmd.uop.op == kpvf_pkg::OP_SUB);

   // Multiplier: four half-width partial products, then shift and saturate
   logic [2*HW-1:0]   ma_ff, mb_ff;
   logic              mneg_ff, mbusy_ff;
   logic [2:0]        mph_ff;
   logic [PW-1:0]     macc_ff;
   kpvf_pkg::dst_type mdst_ff;
   logic [HW-1:0]     ma_h, mb_h;
   logic [2*HW-1:0]   mpp;
   logic [1:0]        mshamt;
   logic [PW-1:0]     mpp_sh, mq, mlim, mmag;
   logic signed [DW-1:0] mres;
   logic              mul_start, mul_fin;

   assign mul_start = cmd.start && (cmd.uop.op == kpvf_pkg::OP_MUL);
   assign mul_fin   = mbusy_ff && (mph_ff == MUL_LAST_PHASE);
   assign ma_h      = mph_ff[0] ? ma_ff[2*HW-1:HW] : ma_ff[HW-1:0];
   assign mb_h      = mph_ff[1] ? mb_ff[2*HW-1:HW] : mb_ff[HW-1:0];
   assign mpp       = ma_h * mb_h;
   assign mshamt    = {1'b0, mph_ff[0]} + {1'b0, mph_ff[1]};
   assign mpp_sh    = PW'(mpp) << (HW * mshamt);
   assign mq        = macc_ff >> FB;
   assign mlim      = PW'({1'b0, {(DW-1){1'b1}}}) + PW'(mneg_ff);
   assign mmag      = (mq > mlim) ? mlim : mq;
   assign mres      = mneg_ff ? $signed(DW'(~mmag[DW-1:0] + 1'b1)) : $signed(mmag[DW-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         mbusy_ff <= 1'b0;
         mph_ff   <= 3'd0;
      end else if (mul_start) begin
         mbusy_ff <= 1'b1;
         mph_ff   <= 3'd0;
      end else if (mul_fin) begin
         mbusy_ff <= 1'b0;
      end else if (mbusy_ff) begin
         mph_ff   <= mph_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (mul_start) begin
         ma_ff   <= (2*HW)'(mag_aw(op_a));
         mb_ff   <= (2*HW)'(mag_aw(op_b));
         mneg_ff <= op_a[AW-1] ^ op_b[AW-1];
         mdst_ff <= cmd.uop.dst;
         macc_ff <= '0;
      end else if (mbusy_ff && !mul_fin) begin
         macc_ff <= macc_ff + mpp_sh;
      end
   end

   // Divider: two restoring lanes (P00/S and P01/S), one quotient bit per cycle
   logic [DN-1:0]   dn_ff   [2];
   logic [DW:0]     dr_ff   [2];
   logic [DW:0]     dq_ff   [2];
   logic            dneg_ff [2];
   logic [DW-1:0]   ud_ff;
   logic            dz_ff, dbusy_ff;
   logic [CW-1:0]   dcnt_ff;
   logic [DW:0]     dr_sh   [2];
   logic [DW:0]     dr_nx   [2];
   logic [DW:0]     dq_sh   [2];
   logic [DW:0]     dq_nx   [2];
   logic [DW:0]     dlim    [2];
   logic [DW:0]     dq_fin  [2];
   logic signed [DW-1:0] dk [2];
   logic            dge     [2];
   logic            div_start, div_fin;
   logic [AW-1:0]   dmag_p00, dmag_p01, dmag_s;

   assign div_start = cmd.start && (cmd.uop.op == kpvf_pkg::OP_DIV);
   assign div_fin   = dbusy_ff && (dcnt_ff == '0);
   assign dmag_p00  = mag_aw(AW'(p00_ff));
   assign dmag_p01  = mag_aw(AW'(p01_ff));
   assign dmag_s    = mag_aw(AW'(s_ff));

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         dr_sh[l]  = {dr_ff[l][DW-1:0], dn_ff[l][DN-1]};
         dge[l]    = dr_sh[l] >= {1'b0, ud_ff};
         dr_nx[l]  = dge[l] ? (dr_sh[l] - {1'b0, ud_ff}) : dr_sh[l];
         dlim[l]   = {2'b00, {(DW-1){1'b1}}} + (DW+1)'(dneg_ff[l]);
         dq_sh[l]  = {dq_ff[l][DW-1:0], dge[l]};
         dq_nx[l]  = (dq_sh[l] > dlim[l]) ? (dlim[l] + 1'b1) : dq_sh[l];
         dq_fin[l] = (dq_ff[l] > dlim[l]) ? dlim[l] : dq_ff[l];
         if (dz_ff) dk[l] = '0;
         else if (dneg_ff[l]) dk[l] = $signed(DW'(~dq_fin[l][DW-1:0] + 1'b1));
         else dk[l] = $signed(dq_fin[l][DW-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dbusy_ff <= 1'b0;
         dcnt_ff  <= '0;
      end else if (div_start) begin
         dbusy_ff <= 1'b1;
         dcnt_ff  <= CW'(DN);
      end else if (div_fin) begin
         dbusy_ff <= 1'b0;
      end else if (dbusy_ff) begin
         dcnt_ff  <= dcnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (div_start) begin
         dn_ff[0]   <= {dmag_p00[DW-1:0], {FB{1'b0}}};
         dn_ff[1]   <= {dmag_p01[DW-1:0], {FB{1'b0}}};
         ud_ff      <= dmag_s[DW-1:0];
         dneg_ff[0] <= p00_ff[DW-1] ^ s_ff[DW-1];
         dneg_ff[1] <= p01_ff[DW-1] ^ s_ff[DW-1];
         dz_ff      <= (s_ff == '0);
         for (int l = 0; l < 2; l++) begin
            dr_ff[l] <= '0;
            dq_ff[l] <= '0;
         end
      end else if (dbusy_ff && !div_fin) begin
         for (int l = 0; l < 2; l++) begin
            dn_ff[l] <= dn_ff[l] << 1;
            dr_ff[l] <= dr_nx[l];
            dq_ff[l] <= dq_nx[l];
         end
      end
   end

   // Shared write port for named destinations
   logic                 wr_en;
   kpvf_pkg::dst_type    wr_dst;
   logic signed [DW-1:0] wr_val;

   always_comb begin
      wr_en  = 1'b0;
      wr_dst = cmd.uop.dst;
      wr_val = alu_res;
      priority if (mul_fin) begin
         wr_en  = 1'b1;
         wr_dst = mdst_ff;
         wr_val = mres;
      end else if (alu_wr) begin
         wr_en  = 1'b1;
      end
   end

   // State registers that reset clears
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         vel_ff <= '0;
         cpp_ff <= ONE_V;
         cpv_ff <= '0;
         cvv_ff <= ONE_V;
      end else if (cmd.start && cmd.uop.op == kpvf_pkg::OP_RESTART) begin
         pos_ff <= '0;
         vel_ff <= '0;
         cpp_ff <= ONE_V;
         cpv_ff <= '0;
         cvv_ff <= ONE_V;
      end else if (cmd.start && cmd.uop.op == kpvf_pkg::OP_CLAMP) begin
         if (cpp_ff[DW-1]) cpp_ff <= '0;
         if (cvv_ff[DW-1]) cvv_ff <= '0;
      end else if (wr_en) begin
         unique case (wr_dst)
            kpvf_pkg::DST_POS: pos_ff <= wr_val;
            kpvf_pkg::DST_VEL: vel_ff <= wr_val;
            kpvf_pkg::DST_CPP: cpp_ff <= wr_val;
            kpvf_pkg::DST_CPV: cpv_ff <= wr_val;
            kpvf_pkg::DST_CVV: cvv_ff <= wr_val;
            default: ;
         endcase
      end
   end

   // Scratch registers, gains, measurement capture and output registers
   always_ff @(posedge clock) begin
      if (wr_en) begin
         unique case (wr_dst)
            kpvf_pkg::DST_X0P: x0p_ff <= wr_val;
            kpvf_pkg::DST_P00: p00_ff <= wr_val;
            kpvf_pkg::DST_P01: p01_ff <= wr_val;
            kpvf_pkg::DST_P11: p11_ff <= wr_val;
            kpvf_pkg::DST_S:   s_ff   <= wr_val;
            kpvf_pkg::DST_Y:   y_ff   <= wr_val;
            kpvf_pkg::DST_OM:  om_ff  <= wr_val;
            kpvf_pkg::DST_T:   t_ff   <= wr_val;
            default: ;
         endcase
      end
      if (div_fin) begin
         k0_ff <= dk[0];
         k1_ff <= dk[1];
      end
      if (cmd.accept) meas_ff <= $signed(meas_in);
      if (cmd.load_out) begin
         pos_out_ff <= out32(pos_ff);
         vel_out_ff <= out32(vel_ff);
      end
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         dt_ff <= kpvf_pkg::TIME_STEP_RST;
         qp_ff <= kpvf_pkg::Q_POSITION_RST;
         qv_ff <= kpvf_pkg::Q_VELOCITY_RST;
         rn_ff <= kpvf_pkg::R_NOISE_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            kpvf_pkg::CSR_TIME_STEP:  dt_ff <= csr_data[16:0];
            kpvf_pkg::CSR_Q_POSITION: qp_ff <= csr_data[30:0];
            kpvf_pkg::CSR_Q_VELOCITY: qv_ff <= csr_data[30:0];
            kpvf_pkg::CSR_R_NOISE:    rn_ff <= csr_data[30:0];
         endcase
      end
   end

   // Completion pulse, registered at the same edge as the result write
   always_ff @(posedge clock) begin
      if (reset) done_ff <= 1'b0;
      else done_ff <= (cmd.start && !mul_start && !div_start) || mul_fin || div_fin;
   end

   assign status.done = done_ff;
   assign position    = pos_out_ff;
   assign velocity    = vel_out_ff;

endmodule

>>> rtl/kpvf_ctrl.sv
// Controller: sequences the update steps and runs the item handshakes.
module kpvf_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  opcode,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output kpvf_pkg::cmd_type     cmd,
   input  kpvf_pkg::status_type  status
);

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_RESTART = 5'b00010,
      ST_ISSUE   = 5'b00100,
      ST_WAIT    = 5'b01000,
      ST_DONE    = 5'b10000
   } state_type;

   state_type                     state_ff, state_in;
   logic [kpvf_pkg::STEP_W-1:0]   step_ff, step_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               step_in    = '0;
               state_in   = opcode ? ST_RESTART : ST_ISSUE;
            end
         end
         ST_RESTART: begin
            cmd.start  = 1'b1;
            cmd.uop    = kpvf_pkg::mk(kpvf_pkg::OP_RESTART, kpvf_pkg::SRC_POS,
                                      kpvf_pkg::SRC_POS, kpvf_pkg::DST_T);
            step_in    = kpvf_pkg::LAST_STEP;
            state_in   = ST_WAIT;
         end
         ST_ISSUE: begin
            cmd.start  = 1'b1;
            cmd.uop    = kpvf_pkg::uop_at(step_ff);
            state_in   = ST_WAIT;
         end
         ST_WAIT: begin
            if (status.done) begin
               if (step_ff == kpvf_pkg::LAST_STEP) begin
                  state_in = ST_DONE;
               end else begin
                  step_in  = step_ff + 1'b1;
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> rtl/kalman_pos_vel_filter_top.sv
// Top level of the two-state position/velocity Kalman filter.
// A measurement item runs the full update sequence; ten 4-partial multiplies and one
// bit-per-cycle divide dominate its run (Q16.16 at the default widths). A restart item
// issues one restart operation. One item at a time; the next is taken while the result waits.
// Reset (synchronous, active high) loads the default configuration and the initial state.
module kalman_pos_vel_filter_top #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] measurement
   input  logic        req_tuser,   // [0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [31:0] position, [63:32] velocity
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   kpvf_pkg::cmd_type    cmd;
   kpvf_pkg::status_type status;
   logic [31:0]          position, velocity;

   assign csr_ready = 1'b1;

   kpvf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .opcode    (req_tuser),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .cmd       (cmd),
      .status    (status)
   );

   kpvf_datapath #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .meas_in   (req_tdata),
      .cmd       (cmd),
      .status    (status),
      .position  (position),
      .velocity  (velocity)
   );

   assign rsp_tdata = {velocity, position};

   // An accepted item leaves the block busy in the cycle after its acceptance
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken while an item is in work");

   // Each issued operation completes once
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      status.done |=> !status.done)
      else $error("completion held for two cycles");

   // An operation is never issued twice back to back
   a_start_pulse: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> !cmd.start)
      else $error("operation issued while one is outstanding");

   // A new result only comes out of a busy block
   a_result_when_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("result appeared without an item in work");

endmodule

>>> verif/kpvf_checker.sv
// Checker for the position/velocity Kalman filter: watches the channels, predicts and compares.
`timescale 1ns / 100ps
module kpvf_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data,
   output int          fail_count,
   output int          pending_count
);

   localparam longint QMAX = 64'sd2147483647;
   localparam longint QMIN = -64'sd2147483648;

   // filter copy
   longint dt_q, qp_q, qv_q, rn_q;
   longint est_pos, est_vel, p_pp, p_pv, p_vv;
   logic [63:0] estimate_q[$];

   function automatic longint clip(input longint v);
      if (v > QMAX) return QMAX;
      if (v < QMIN) return QMIN;
      return v;
   endfunction

   // exact product, magnitude shifted toward zero, then saturated
   function automatic longint fx_mul(input longint a, input longint b);
      logic [127:0] pm;
      logic [127:0] lim;
      logic neg;
      longint ma, mb;
      neg = (a < 0) != (b < 0);
      ma = a < 0 ? -a : a;
      mb = b < 0 ? -b : b;
      pm = (128'(ma) * 128'(mb)) >> 16;
      lim = neg ? 128'(QMAX) + 1 : 128'(QMAX);
      if (pm > lim) pm = lim;
      return neg ? -longint'(pm[63:0]) : longint'(pm[63:0]);
   endfunction

   function automatic longint fx_div(input longint n, input longint d);
      logic [127:0] q;
      logic [127:0] lim;
      logic neg;
      longint mn, md;
      if (d == 0) return 0;
      neg = (n < 0) != (d < 0);
      mn = n < 0 ? -n : n;
      md = d < 0 ? -d : d;
      q = (128'(mn) << 16) / 128'(md);
      lim = neg ? 128'(QMAX) + 1 : 128'(QMAX);
      if (q > lim) q = lim;
      return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
   endfunction

   task automatic restart_filter();
      est_pos = 0; est_vel = 0; p_pp = 65536; p_pv = 0; p_vv = 65536;
   endtask

   task automatic measure_update(input logic signed [31:0] z);
      longint x0p, p00, p01, p11, s, k0, k1, y, om;
      x0p = clip(est_pos + fx_mul(dt_q, est_vel));
      p00 = clip(p_pp + fx_mul(dt_q, clip(p_pv + p_pv)));
      p00 = clip(p00 + fx_mul(fx_mul(dt_q, dt_q), p_vv));
      p00 = clip(p00 + qp_q);
      p01 = clip(p_pv + fx_mul(dt_q, p_vv));
      p11 = clip(p_vv + qv_q);
      s = clip(p00 + rn_q);
      k0 = fx_div(p00, s);
      k1 = fx_div(p01, s);
      y = clip(longint'(z) - x0p);
      est_pos = clip(x0p + fx_mul(k0, y));
      est_vel = clip(est_vel + fx_mul(k1, y));
      om = clip(65536 - k0);
      p_pp = fx_mul(om, p00);
      p_pv = fx_mul(om, p01);
      p_vv = clip(p11 - fx_mul(k1, p01));
      if (p_pp < 0) p_pp = 0;
      if (p_vv < 0) p_vv = 0;
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("ERROR %0t: %s got %h expected %h", $realtime, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      logic [63:0] want;
      if (reset) begin
         dt_q = kpvf_pkg::TIME_STEP_RST; qp_q = kpvf_pkg::Q_POSITION_RST;
         qv_q = kpvf_pkg::Q_VELOCITY_RST; rn_q = kpvf_pkg::R_NOISE_RST;
         restart_filter();
         estimate_q.delete();
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               kpvf_pkg::CSR_TIME_STEP:  dt_q = csr_data[16:0];
               kpvf_pkg::CSR_Q_POSITION: qp_q = csr_data[30:0];
               kpvf_pkg::CSR_Q_VELOCITY: qv_q = csr_data[30:0];
               kpvf_pkg::CSR_R_NOISE:    rn_q = csr_data[30:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (estimate_q.size() == 0) begin
               report_mismatch("unexpected item", rsp_tdata[31:0], 32'd0);
            end else begin
               want = estimate_q.pop_front();
               if (rsp_tdata[31:0] !== want[31:0])
                  report_mismatch("position", rsp_tdata[31:0], want[31:0]);
               if (rsp_tdata[63:32] !== want[63:32])
                  report_mismatch("velocity", rsp_tdata[63:32], want[63:32]);
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser) restart_filter();
            else measure_update(req_tdata);
            estimate_q.push_back({est_vel[31:0], est_pos[31:0]});
         end
      end
      pending_count = estimate_q.size();
   end
endmodule

>>> verif/tb_kalman_pos_vel_filter_top.sv
// Testbench top for the position/velocity Kalman filter: stimulus, stalls and verdict.
`timescale 1ns / 100ps
module tb_kalman_pos_vel_filter_top;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_data = '0;
   int          fail_count, pending_count;
   int          stall_mode = 0;

   always #2 clock = ~clock;

   kalman_pos_vel_filter_top dut (.*);

   kpvf_checker u_checker (.*);

   // receiver stalls: mode picks always-ready, light or heavy back-pressure
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         default: rsp_tready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // one item; valid stays high across back-to-back items when hold is set
   task automatic send_item(input logic op, input logic [31:0] z, input bit hold);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= z;
      do @(posedge clock); while (!req_tready);
      if (!hold) req_tvalid <= 1'b0;
   endtask

   task automatic drain();
      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_meas();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return 32'h7fffffff;
         2: return 32'h80000000;
         default: return 32'($signed($urandom_range(0, 20000000)) - 10000000);
      endcase
   endfunction

   initial begin
      logic [31:0] ts[4];
      logic [31:0] lo_cfg[4];
      int left, burst;
      ts     = '{32'd655, 32'd65536, 32'd0, 32'hfffe8000};
      lo_cfg = '{32'd0, 32'h7fffffff, 32'd1, 32'hffffffff};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset defaults, field extremes, restart
      send_item(1'b0, 32'h7fffffff, 0);
      send_item(1'b0, 32'h80000000, 0);
      send_item(1'b0, 32'h0, 0);
      send_item(1'b1, 32'hffffffff, 0);
      send_item(1'b0, 32'h00010000, 0);
      drain();
      // zero divisor: r = 0 with collapsed covariance
      write_reg(kpvf_pkg::CSR_R_NOISE, 32'd0);
      write_reg(kpvf_pkg::CSR_Q_POSITION, 32'd0);
      write_reg(kpvf_pkg::CSR_TIME_STEP, 32'd0);
      write_reg(kpvf_pkg::CSR_Q_VELOCITY, 32'h7fffffff);
      for (int i = 0; i < 6; i++) send_item(1'b0, rand_meas(), 0);
      send_item(1'b0, 32'h5555aaaa, 0);
      drain();
      // large noise, full step: saturation paths
      write_reg(kpvf_pkg::CSR_R_NOISE, 32'h7fffffff);
      write_reg(kpvf_pkg::CSR_Q_POSITION, 32'h7fffffff);
      write_reg(kpvf_pkg::CSR_TIME_STEP, 32'd65536);
      for (int i = 0; i < 6; i++) send_item(1'b0, rand_meas(), 0);
      send_item(1'b1, 32'd0, 0);
      drain();

      // random phases across settings
      for (int ph = 0; ph < 12; ph++) begin
         stall_mode = ph % 3;
         if (ph % 4 == 3) begin
            write_reg(kpvf_pkg::CSR_TIME_STEP, lo_cfg[$urandom_range(0, 3)]);
            write_reg(kpvf_pkg::CSR_Q_POSITION, lo_cfg[$urandom_range(0, 3)]);
            write_reg(kpvf_pkg::CSR_Q_VELOCITY, lo_cfg[$urandom_range(0, 3)]);
            write_reg(kpvf_pkg::CSR_R_NOISE, lo_cfg[$urandom_range(0, 3)]);
         end else begin
            write_reg(kpvf_pkg::CSR_TIME_STEP, ts[ph % 4] ^ ($urandom & 32'h3ff));
            write_reg(kpvf_pkg::CSR_Q_POSITION, $urandom_range(0, 200000));
            write_reg(kpvf_pkg::CSR_Q_VELOCITY, $urandom_range(0, 200000));
            write_reg(kpvf_pkg::CSR_R_NOISE, $urandom_range(1, 2000000));
         end
         left = 160;
         while (left > 0) begin
            burst = $urandom_range(1, 12);
            if (burst > left) burst = left;
            for (int b = 0; b < burst; b++)
               send_item(($urandom_range(0, 29) == 0), rand_meas(), b != burst - 1);
            left -= burst;
            if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 200)) @(posedge clock);
         end
         drain();
      end

      if (fail_count == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // watchdog: ~2000 items plus stalls fit easily
   initial begin
      #8000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
